/* rtl/core/npg_pkg.sv */
// ----------------------------------------------------------------------------
// npg_pkg: shared types, constants and helpers for the next permutation unit
// Element packing and unpacking, lane vectors and the pivot search struct.
// ----------------------------------------------------------------------------
package npg_pkg;

  // Sequence geometry
  localparam int NUM_ELEMENTS = 8;
  localparam int ELEM_BITS    = 4;
  localparam int SEQ_W        = 32;
  localparam int PACK_W       = NUM_ELEMENTS * ELEM_BITS;
  localparam int EXT_W        = (PACK_W > SEQ_W) ? PACK_W : SEQ_W;
  localparam int IDX_W        = $clog2(NUM_ELEMENTS);

  typedef logic [ELEM_BITS-1:0]                    elem_t;
  typedef logic [NUM_ELEMENTS-1:0][ELEM_BITS-1:0]  elem_arr_t;
  typedef logic [IDX_W-1:0]                        idx_t;
  typedef logic [SEQ_W-1:0]                        seq_t;

  // Pivot search result handed from the scan stage to the rebuild stage
  typedef struct packed {
    logic found;
    idx_t pivot;
  } find_t;

  // Split a word into elements; bits above the word read as zero
  function automatic elem_arr_t unpack_seq(input seq_t word);
    logic [EXT_W-1:0] ext;
    elem_arr_t        e;
    ext = EXT_W'(word);
    for (int k = 0; k < NUM_ELEMENTS; k++) begin
      e[k] = ext[k*ELEM_BITS +: ELEM_BITS];
    end
    return e;
  endfunction

  // Put elements back over the original word; bits above the elements pass
  function automatic seq_t pack_seq(input seq_t word, input elem_arr_t e);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(word);
    for (int k = 0; k < NUM_ELEMENTS; k++) begin
      ext[k*ELEM_BITS +: ELEM_BITS] = e[k];
    end
    return ext[SEQ_W-1:0];
  endfunction

endpackage

/* rtl/core/npg_lane.sv */
// ----------------------------------------------------------------------------
// npg_lane: one compare lane
// Unsigned less-than between two elements; replicated across the sequence.
// ----------------------------------------------------------------------------
module npg_lane (
  input  npg_pkg::elem_t lhs,
  input  npg_pkg::elem_t rhs,
  output logic           less
);
  import npg_pkg::*;

  assign less = (lhs < rhs);

endmodule

/* rtl/core/npg_find.sv */
// ----------------------------------------------------------------------------
// npg_find: pivot search
// Picks the rightmost ascent reported by the lanes.
// ----------------------------------------------------------------------------
module npg_find (
  input  logic [npg_pkg::NUM_ELEMENTS-2:0] ascent,
  output npg_pkg::find_t                   find
);
  import npg_pkg::*;

  // Highest-index set bit wins
  always_comb begin
    find = '0;
    for (int k = 0; k < NUM_ELEMENTS - 1; k++) begin
      if (ascent[k]) begin
        find.found = 1'b1;
        find.pivot = IDX_W'(k);
      end
    end
  end

endmodule

/* rtl/core/npg_merge.sv */
// ----------------------------------------------------------------------------
// npg_merge: successor rebuild
// Picks the swap partner from the lane results, swaps it with the pivot and
// reverses the tail after the pivot.
// ----------------------------------------------------------------------------
module npg_merge (
  input  npg_pkg::seq_t                    word,
  input  npg_pkg::find_t                   find,
  input  logic [npg_pkg::NUM_ELEMENTS-1:0] above,
  output npg_pkg::seq_t                    seq_out,
  output logic                             has_next
);
  import npg_pkg::*;

  elem_arr_t elems;
  idx_t      partner;

  assign elems = unpack_seq(word);

  // Rightmost element past the pivot that is larger than it
  always_comb begin
    partner = find.pivot;
    for (int k = 0; k < NUM_ELEMENTS; k++) begin
      if (above[k] && (IDX_W'(k) > find.pivot)) begin
        partner = IDX_W'(k);
      end
    end
  end

  // Swap and tail reversal, one mux per position
  always_comb begin
    elem_arr_t        res;
    logic [IDX_W:0]   src_ext;
    idx_t             src;
    res     = elems;
    src_ext = '0;
    src     = '0;
    for (int p = 0; p < NUM_ELEMENTS; p++) begin
      if (find.found) begin
        if (IDX_W'(p) == find.pivot) begin
          res[p] = elems[partner];
        end else if (IDX_W'(p) > find.pivot) begin
          // mirror position within the tail
          src_ext = (IDX_W+1)'(NUM_ELEMENTS) + {1'b0, find.pivot} - (IDX_W+1)'(p);
          src     = src_ext[IDX_W-1:0];
          res[p]  = (src == partner) ? elems[find.pivot] : elems[src];
        end
      end
    end
    seq_out = pack_seq(word, res);
  end

  assign has_next = find.found;

endmodule

/* rtl/core/next_permutation_generator_unit.sv */
// ----------------------------------------------------------------------------
// next_permutation_generator_unit: lexicographic next permutation
// Two-stage lane pipeline with a registered result word.
// ----------------------------------------------------------------------------
// Takes one packed sequence per word and returns its lexicographic successor
// (repeated values give multiset order); on the last permutation the word
// comes back unchanged with has_next low. Accepts one word per cycle while
// the pipeline is not stalled. Each result passes the two register stages in
// order: the ascent lanes with the pivot search, then the pivot compare
// lanes with the swap and reversal. A stalled result holds the whole pipeline.
module next_permutation_generator_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  npg_pkg::seq_t in_sequence_in,
  output logic          out_valid,
  input  logic          out_stall,
  output npg_pkg::seq_t out_sequence_out,
  output logic          out_has_next
);
  import npg_pkg::*;

  logic                    advance;
  elem_arr_t               elems_a;
  logic [NUM_ELEMENTS-2:0] ascent;
  find_t                   find_a;

  logic                    s1_valid_r, s1_valid_nxt;
  seq_t                    s1_word_r;
  find_t                   s1_find_r;

  elem_arr_t               elems_b;
  elem_t                   pivot_elem;
  logic [NUM_ELEMENTS-1:0] above;
  seq_t                    merged_seq;
  logic                    merged_next;

  logic                    out_valid_r, out_valid_nxt;
  seq_t                    out_seq_r;
  logic                    out_has_next_r;

  // Pipeline moves whenever the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Stage A: ascent lanes and pivot search
  assign elems_a = unpack_seq(in_sequence_in);

  for (genvar k = 0; k < NUM_ELEMENTS - 1; k++) begin : g_ascent
    npg_lane u_lane (
      .lhs  (elems_a[k]),
      .rhs  (elems_a[k+1]),
      .less (ascent[k])
    );
  end

  npg_find u_find (
    .ascent (ascent),
    .find   (find_a)
  );

  assign s1_valid_nxt = advance ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_word_r <= in_sequence_in;
      s1_find_r <= find_a;
    end
  end

  // Stage B: compare every element against the pivot, then rebuild
  assign elems_b    = unpack_seq(s1_word_r);
  assign pivot_elem = elems_b[s1_find_r.pivot];

  for (genvar k = 0; k < NUM_ELEMENTS; k++) begin : g_above
    npg_lane u_lane (
      .lhs  (pivot_elem),
      .rhs  (elems_b[k]),
      .less (above[k])
    );
  end

  npg_merge u_merge (
    .word     (s1_word_r),
    .find     (s1_find_r),
    .above    (above),
    .seq_out  (merged_seq),
    .has_next (merged_next)
  );

  // Result register
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_seq_r      <= merged_seq;
      out_has_next_r <= merged_next;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sequence_out = out_seq_r;
  assign out_has_next     = out_has_next_r;

  // An accepted word reaches stage B on the next edge
  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted word did not enter stage B");

  // Stage B contents reach the result register when the pipeline moves
  a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r |=> out_valid_r)
    else $error("stage B word lost on its way to the result register");

  // No successor means the word passes through unchanged
  a_last_passes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_valid_r && !s1_find_r.found
      |=> !out_has_next_r && (out_seq_r == $past(s1_word_r)))
    else $error("last permutation was altered");

  // A found pivot always has a right neighbor
  a_pivot_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_find_r.found |-> (int'(s1_find_r.pivot) <= NUM_ELEMENTS - 2))
    else $error("pivot index past the last ascent position");

endmodule
